/* sv/fdf_pkg.sv */
// Shared types and constants for the frame deframer.
// Used by fdf_front, fdf_queue, fdf_back and the top level.
package fdf_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 1024;
	localparam int unsigned POS_W           = 10;
	localparam int unsigned OUT_DATA_W      = 88;
	localparam int unsigned OUT_USER_W      = 3;

	// header byte positions
	localparam logic [2:0] HDR_TYPE   = 3'd0;
	localparam logic [2:0] HDR_SEQ    = 3'd1;
	localparam logic [2:0] HDR_LEN_HI = 3'd2;
	localparam logic [2:0] HDR_LEN_LO = 3'd3;
	localparam logic [2:0] HDR_SUM_HI = 3'd4;
	localparam logic [2:0] HDR_SUM_LO = 3'd5;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_OK       = 2'd1,
		KIND_SHORT    = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	// one classified byte, handed from the front to the back
	typedef struct packed {
		logic [7:0]       data;
		logic             hdr_byte;
		logic [2:0]       hdr_idx;
		logic             add;
		logic             emit;
		kind_t            kind;
		logic             present;
		logic [POS_W-1:0] pos;
		logic             with_hdr;
		logic             with_sum;
	} tok_t;

endpackage

/* sv/frame_deframer_with_checksum.sv */
// Frame deframer with a ones' complement byte-sum checksum.
// Input stream (s_*): one buffer byte per transfer, s_tlast on the buffer's final byte.
// Each buffer holds a six-byte header (type, sequence, big-endian length,
// big-endian checksum) followed by the payload. Output stream (m_*): one
// transfer per payload byte, plus one status transfer per frame: complete ok,
// buffer too short, or length too large; a complete frame's last payload byte
// rides on its ok status. The status of a complete frame carries the
// complemented end-around-carry sum of type, sequence, length and payload
// bytes beside the received checksum. Bytes after a finished or failed frame
// are dropped until the final byte of the buffer. Throughput: one byte per cycle
// while the queue has room; a result passes front parse, queue, back register.
// A two-entry queue separates the parser from the checksum/output stage, so
// input keeps flowing while a result waits. When m_tready stays low the queue
// fills and s_tready drops after two more bytes; bytes that give no result
// still drain past a stalled output.
// Reset clears the parser to the start of a header and empties the queue.
// Depends on fdf_pkg, fdf_front, fdf_queue, fdf_back.
module frame_deframer_with_checksum #(
	parameter int unsigned MAX_PAYLOAD_BYTES = fdf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] data_byte
	input  logic                           s_tlast,  // end_of_buffer
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] payload_value, [17:8] payload_position, [25:18] frame_type,
	// [33:26] sequence_number, [49:34] payload_length, [65:50] received_sum,
	// [81:66] computed_sum, [87:82] zero
	output logic [fdf_pkg::OUT_DATA_W-1:0] m_tdata,
	// [1:0] result_kind, [2] byte_present
	output logic [fdf_pkg::OUT_USER_W-1:0] m_tuser
);
	import fdf_pkg::*;

	logic accept;
	logic q_full;
	logic q_avail;
	logic q_pop;
	tok_t front_tok;
	tok_t q_head;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	fdf_front #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (s_tdata),
		.end_of_buffer(s_tlast),
		.tok          (front_tok)
	);

	fdf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_tok(front_tok),
		.full    (q_full),
		.pop     (q_pop),
		.avail   (q_avail),
		.head    (q_head)
	);

	fdf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.avail   (q_avail),
		.head    (q_head),
		.pop     (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// error results never carry a payload byte
	a_no_byte_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_SHORT || m_tuser[1:0] == KIND_TOO_LONG)
		|-> !m_tuser[2])
		else $error("payload byte flagged on an error result");

	// a plain payload result always carries its byte
	a_payload_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_PAYLOAD) |-> m_tuser[2])
		else $error("payload result without a byte");

	// the computed sum is reported only with a completed frame
	a_sum_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != KIND_OK) |-> (m_tdata[81:66] == 16'd0))
		else $error("computed sum on a result that is not frame complete");

	// a result held in the output register blocks the queue from draining it
	a_pop_respects_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && q_pop |-> !q_head.emit)
		else $error("result popped while the output register is stalled");

endmodule

/* sv/fdf_front.sv */
// Front end of the frame deframer: parses the byte stream and classifies each byte.
// Depends on fdf_pkg; feeds fdf_queue.
module fdf_front #(
	parameter int unsigned MAX_PAYLOAD_BYTES = fdf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          end_of_buffer,
	output fdf_pkg::tok_t tok
);
	import fdf_pkg::*;

	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_WAIT    = 2'd2
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [15:0] cnt_q, cnt_n;
	logic [15:0] len_q, len_n;
	logic [16:0] cnt_inc;

	assign cnt_inc = {1'b0, cnt_q} + 17'd1;

	always_comb begin
		tok     = '0;
		tok.kind = KIND_PAYLOAD;
		phase_n = phase_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		tok.data = data_byte;
		unique case (phase_q)
			PH_HEADER: begin
				tok.hdr_byte = 1'b1;
				tok.hdr_idx  = cnt_q[2:0];
				tok.add      = (cnt_q < 16'd4);
				if (cnt_q[2:0] == HDR_TYPE) begin
					len_n = '0;
				end else if (cnt_q[2:0] == HDR_LEN_HI) begin
					len_n = {data_byte, 8'h00};
				end else if (cnt_q[2:0] == HDR_LEN_LO) begin
					len_n = {len_q[15:8], data_byte};
				end
				if (cnt_q[2:0] == HDR_SUM_LO) begin
					cnt_n = '0;
					priority if (len_q > MAX_LEN) begin
						tok.emit     = 1'b1;
						tok.kind     = KIND_TOO_LONG;
						tok.with_hdr = 1'b1;
						phase_n      = PH_WAIT;
					end else if (len_q == 16'd0) begin
						tok.emit     = 1'b1;
						tok.kind     = KIND_OK;
						tok.with_hdr = 1'b1;
						tok.with_sum = 1'b1;
						phase_n      = PH_WAIT;
					end else if (end_of_buffer) begin
						tok.emit     = 1'b1;
						tok.kind     = KIND_SHORT;
						tok.with_hdr = 1'b1;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else if (end_of_buffer) begin
					tok.emit = 1'b1;
					tok.kind = KIND_SHORT;
				end else begin
					cnt_n = cnt_inc[15:0];
				end
			end
			PH_PAYLOAD: begin
				tok.add = 1'b1;
				priority if (cnt_inc >= {1'b0, len_q}) begin
					tok.emit     = 1'b1;
					tok.kind     = KIND_OK;
					tok.present  = 1'b1;
					tok.pos      = cnt_q[POS_W-1:0];
					tok.with_hdr = 1'b1;
					tok.with_sum = 1'b1;
					phase_n      = PH_WAIT;
					cnt_n        = '0;
				end else if (end_of_buffer) begin
					tok.emit     = 1'b1;
					tok.kind     = KIND_SHORT;
					tok.with_hdr = 1'b1;
				end else begin
					tok.emit     = 1'b1;
					tok.kind     = KIND_PAYLOAD;
					tok.present  = 1'b1;
					tok.pos      = cnt_q[POS_W-1:0];
					tok.with_hdr = 1'b1;
					cnt_n        = cnt_inc[15:0];
				end
			end
			default: begin
				// wait for the final byte of the buffer
			end
		endcase
		if (end_of_buffer) begin
			phase_n = PH_HEADER;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
		end
	end

endmodule

/* sv/fdf_queue.sv */
// Two-entry queue of classified bytes between the front and back ends.
// Depends on fdf_pkg for the token type.
module fdf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fdf_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output fdf_pkg::tok_t head
);
	import fdf_pkg::*;

	tok_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* sv/fdf_back.sv */
// Back end of the frame deframer: holds header fields, the folded byte sum,
// and the output register. Depends on fdf_pkg; drains fdf_queue.
module fdf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              avail,
	input  fdf_pkg::tok_t                     head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fdf_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [fdf_pkg::OUT_USER_W-1:0]    m_tuser
);
	import fdf_pkg::*;

	logic [7:0]  type_q, type_n;
	logic [7:0]  seq_q, seq_n;
	logic [15:0] len_q, len_n;
	logic [15:0] rsum_q, rsum_n;
	logic [15:0] sum_q, sum_n;
	logic [15:0] sum_base;
	logic [16:0] sum_raw;
	logic [15:0] sum_fold;
	logic        clear;

	logic        out_valid_q;
	kind_t       kind_q;
	logic        present_q;
	logic [7:0]  value_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]  otype_q;
	logic [7:0]  oseq_q;
	logic [15:0] olen_q;
	logic [15:0] orsum_q;
	logic [15:0] ocsum_q;

	assign pop = avail && (!head.emit || !out_valid_q || m_tready);

	assign clear    = head.hdr_byte && (head.hdr_idx == HDR_TYPE);
	assign sum_base = clear ? 16'd0 : sum_q;
	assign sum_raw  = {1'b0, sum_base} + {9'd0, head.data};
	// end-around carry; the low half is small whenever the carry is set
	assign sum_fold = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
	assign sum_n    = head.add ? sum_fold : sum_base;

	always_comb begin
		type_n = clear ? 8'd0 : type_q;
		seq_n  = clear ? 8'd0 : seq_q;
		len_n  = clear ? 16'd0 : len_q;
		rsum_n = clear ? 16'd0 : rsum_q;
		if (head.hdr_byte) begin
			unique case (head.hdr_idx)
				HDR_TYPE:   type_n = head.data;
				HDR_SEQ:    seq_n  = head.data;
				HDR_LEN_HI: len_n  = {head.data, 8'h00};
				HDR_LEN_LO: len_n  = {len_q[15:8], head.data};
				HDR_SUM_HI: rsum_n = {head.data, 8'h00};
				HDR_SUM_LO: rsum_n = {rsum_q[15:8], head.data};
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0;
			seq_q  <= '0;
			len_q  <= '0;
			rsum_q <= '0;
			sum_q  <= '0;
		end else if (pop) begin
			type_q <= type_n;
			seq_q  <= seq_n;
			len_q  <= len_n;
			rsum_q <= rsum_n;
			sum_q  <= sum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.emit) begin
			kind_q    <= head.kind;
			present_q <= head.present;
			value_q   <= head.present ? head.data : 8'd0;
			pos_q     <= head.pos;
			otype_q   <= head.with_hdr ? type_n : 8'd0;
			oseq_q    <= head.with_hdr ? seq_n : 8'd0;
			olen_q    <= head.with_hdr ? len_n : 16'd0;
			orsum_q   <= head.with_hdr ? rsum_n : 16'd0;
			ocsum_q   <= head.with_sum ? ~sum_n : 16'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {present_q, kind_q};
	assign m_tdata  = {6'd0, ocsum_q, orsum_q, olen_q, oseq_q, otype_q, pos_q, value_q};

endmodule

/* dv/testbench.sv */
// Self-checking testbench for frame_deframer_with_checksum: drives byte buffers on the
// input stream, predicts every output transfer and compares it field by field.
// Depends on fdf_pkg and the frame_deframer_with_checksum RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fdf_pkg::*;

	localparam int unsigned MAX_LEN = MAX_PAYLOAD_DEF;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_SKIP
	} parse_phase_t;

	typedef struct packed {
		kind_t            kind;
		logic             present;
		logic [7:0]       value;
		logic [POS_W-1:0] pos;
		logic [7:0]       ftype;
		logic [7:0]       seq;
		logic [15:0]      len;
		logic [15:0]      rsum;
		logic [15:0]      csum;
	} frame_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	frame_deframer_with_checksum #(.MAX_PAYLOAD_BYTES(MAX_LEN)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// predictor state
	parse_phase_t parse_ph = PH_HEADER;
	logic [15:0]  parse_cnt = '0;
	logic [7:0]   hdr_type = '0;
	logic [7:0]   hdr_seq = '0;
	logic [15:0]  hdr_len = '0;
	logic [15:0]  hdr_rsum = '0;
	logic [15:0]  byte_sum = '0;

	frame_result_t pending_results[$];
	logic [7:0]    tx_buf[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_req_id = 0;
	int bytes_parsed = 0;
	int errors = 0;
	int n_ok = 0;
	int n_short = 0;
	int n_oversize = 0;
	int n_payload = 0;
	bit drain_stuck = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6ms;
		$display("%0t: timeout", $time);
		$display("testbench: done, errors");
		$finish;
	end

	// one's complement add with end-around carry
	function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [7:0] b);
		logic [16:0] t;
		t = {1'b0, acc} + {9'd0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	function automatic void push_result(input kind_t k, input logic present,
			input logic [7:0] v, input logic [POS_W-1:0] pos, input logic with_hdr,
			input logic [15:0] csum);
		frame_result_t r;
		r.kind    = k;
		r.present = present;
		r.value   = present ? v : 8'h00;
		r.pos     = present ? pos : '0;
		r.ftype   = with_hdr ? hdr_type : 8'h00;
		r.seq     = with_hdr ? hdr_seq : 8'h00;
		r.len     = with_hdr ? hdr_len : 16'h0000;
		r.rsum    = with_hdr ? hdr_rsum : 16'h0000;
		r.csum    = csum;
		pending_results.push_back(r);
	endfunction

	// advance the parser model by one accepted byte
	task automatic deframe_byte(input logic [7:0] b, input logic last);
		logic [15:0] pos;
		if (parse_ph != PH_SKIP)
			bytes_parsed++;
		if (parse_ph == PH_HEADER) begin
			if (parse_cnt == 0) begin
				hdr_type = '0;
				hdr_seq  = '0;
				hdr_len  = '0;
				hdr_rsum = '0;
				byte_sum = '0;
			end
			case (parse_cnt[2:0])
				HDR_TYPE: begin
					hdr_type = b;
					byte_sum = fold_add(byte_sum, b);
				end
				HDR_SEQ: begin
					hdr_seq  = b;
					byte_sum = fold_add(byte_sum, b);
				end
				HDR_LEN_HI: begin
					hdr_len  = {b, 8'h00};
					byte_sum = fold_add(byte_sum, b);
				end
				HDR_LEN_LO: begin
					hdr_len[7:0] = b;
					byte_sum     = fold_add(byte_sum, b);
				end
				HDR_SUM_HI: hdr_rsum = {b, 8'h00};
				default: hdr_rsum[7:0] = b;
			endcase
			if (parse_cnt >= 5) begin
				parse_cnt = '0;
				if (hdr_len > MAX_LEN) begin
					push_result(KIND_TOO_LONG, 1'b0, 8'h00, '0, 1'b1, 16'h0000);
					parse_ph = PH_SKIP;
				end else if (hdr_len == 0) begin
					push_result(KIND_OK, 1'b0, 8'h00, '0, 1'b1, ~byte_sum);
					parse_ph = PH_SKIP;
				end else if (last) begin
					push_result(KIND_SHORT, 1'b0, 8'h00, '0, 1'b1, 16'h0000);
				end else begin
					parse_ph = PH_PAYLOAD;
				end
			end else if (last) begin
				push_result(KIND_SHORT, 1'b0, 8'h00, '0, 1'b0, 16'h0000);
			end else begin
				parse_cnt++;
			end
		end else if (parse_ph == PH_PAYLOAD) begin
			pos      = parse_cnt;
			byte_sum = fold_add(byte_sum, b);
			if (int'(pos) + 1 >= int'(hdr_len)) begin
				push_result(KIND_OK, 1'b1, b, pos[POS_W-1:0], 1'b1, ~byte_sum);
				parse_ph  = PH_SKIP;
				parse_cnt = '0;
			end else if (last) begin
				push_result(KIND_SHORT, 1'b0, 8'h00, '0, 1'b1, 16'h0000);
			end else begin
				push_result(KIND_PAYLOAD, 1'b1, b, pos[POS_W-1:0], 1'b1, 16'h0000);
				parse_cnt = pos + 16'd1;
			end
		end
		if (last) begin
			parse_ph  = PH_HEADER;
			parse_cnt = '0;
		end
	endtask

	// receiver: random stalls, plus a long hold-off when a test requests one
	always @(posedge clk) begin : receiver_p
		int hold_left;
		int hold_ack_id;
		if (hold_req_id != hold_ack_id) begin
			hold_ack_id = hold_req_id;
			hold_left   = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : checker_p
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual user %h data %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.kind, m_tuser[1:0]);
				check_field("byte_present", want.present, m_tuser[2]);
				check_field("payload_value", want.value, m_tdata[7:0]);
				check_field("payload_position", want.pos, m_tdata[17:8]);
				check_field("frame_type", want.ftype, m_tdata[25:18]);
				check_field("sequence_number", want.seq, m_tdata[33:26]);
				check_field("payload_length", want.len, m_tdata[49:34]);
				check_field("received_sum", want.rsum, m_tdata[65:50]);
				check_field("computed_sum", want.csum, m_tdata[81:66]);
			end
			case (m_tuser[1:0])
				KIND_PAYLOAD: n_payload++;
				KIND_OK: n_ok++;
				KIND_SHORT: n_short++;
				default: n_oversize++;
			endcase
		end
	end

	// offer one byte, with random idle cycles ahead of it, and hold until the transfer
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		deframe_byte(b, last);
	endtask

	task automatic send_buffer();
		foreach (tx_buf[i])
			send_byte(tx_buf[i], i == tx_buf.size() - 1);
		tx_buf.delete();
	endtask

	task automatic queue_header(input logic [7:0] ftype, input logic [7:0] seq,
			input logic [15:0] len, input logic [15:0] rsum);
		tx_buf.push_back(ftype);
		tx_buf.push_back(seq);
		tx_buf.push_back(len[15:8]);
		tx_buf.push_back(len[7:0]);
		tx_buf.push_back(rsum[15:8]);
		tx_buf.push_back(rsum[7:0]);
	endtask

	task automatic queue_random(input int n);
		repeat (n)
			tx_buf.push_back(8'($urandom_range(255)));
	endtask

	// stop offering and wait until every predicted result has been seen
	task automatic wait_results_done();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			drain_stuck = 1'b1;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		repeat (8) @(posedge clk);
	endtask

	// mostly good frames, the rest truncated, oversize or empty
	task automatic build_random_buffer();
		int sel;
		int len;
		sel = $urandom_range(99);
		if (sel < 66) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(80, 17) : $urandom_range(16, 1);
			queue_header(8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len),
				16'($urandom_range(65535)));
			queue_random(len);
			if ($urandom_range(2) == 0)
				queue_random($urandom_range(4, 1));
		end else if (sel < 74) begin
			queue_header(8'($urandom_range(255)), 8'($urandom_range(255)), 16'h0000,
				16'($urandom_range(65535)));
			queue_random($urandom_range(3));
		end else if (sel < 84) begin
			len = ($urandom_range(3) == 0) ? MAX_LEN + 1 : $urandom_range(65535, MAX_LEN + 1);
			queue_header(8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len),
				16'($urandom_range(65535)));
			queue_random($urandom_range(3));
		end else if (sel < 93) begin
			len = $urandom_range(20, 1);
			queue_header(8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len),
				16'($urandom_range(65535)));
			queue_random($urandom_range(len - 1));
		end else begin
			queue_random($urandom_range(5, 1));
		end
	endtask

	task automatic test_directed();
		// single byte buffer, ends in the header
		tx_buf.push_back(8'hFF);
		send_buffer();
		// empty payload, completes on the header's last byte which also ends the buffer
		queue_header(8'h00, 8'hFF, 16'h0000, 16'h807F);
		send_buffer();
		// just over the limit, followed by an ignored byte
		queue_header(8'hAA, 8'h55, 16'(MAX_LEN + 1), 16'h0000);
		tx_buf.push_back(8'h11);
		send_buffer();
		// two payload bytes at the extremes, then a trailing byte to drop
		queue_header(8'h5A, 8'hA5, 16'h0002, 16'hFFFF);
		tx_buf.push_back(8'hFF);
		tx_buf.push_back(8'h00);
		tx_buf.push_back(8'h33);
		send_buffer();
		// buffer ends inside the payload
		queue_header(8'h01, 8'h02, 16'h0003, 16'h1234);
		tx_buf.push_back(8'h77);
		send_buffer();
		wait_results_done();
	endtask

	task automatic test_random_frames(input int n_bytes, input int idle_pct,
			input int stall_pct);
		int start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = bytes_parsed;
		while (bytes_parsed - start < n_bytes) begin
			build_random_buffer();
			send_buffer();
		end
		wait_results_done();
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		int start;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len       = 150;
		hold_req_id++;
		start = bytes_parsed;
		while (bytes_parsed - start < 60) begin
			build_random_buffer();
			send_buffer();
		end
		wait_results_done();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_frames(180, 0, 0);
		test_random_frames(180, 85, 0);
		test_random_frames(180, 0, 85);
		test_random_frames(180, 30, 30);
		test_backpressure();
		$display("run covered %0d parsed bytes: %0d frames ok, %0d short, %0d oversize,",
			bytes_parsed, n_ok, n_short, n_oversize);
		$display("  %0d payload transfers, under sender gaps, receiver stalls and a long hold-off",
			n_payload);
		if (errors == 0 && !drain_stuck)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* files.f */
sv/fdf_pkg.sv
sv/fdf_front.sv
sv/fdf_queue.sv
sv/fdf_back.sv
sv/frame_deframer_with_checksum.sv
dv/testbench.sv
